// File: hw/rtl/i2cdac_pkg.sv
package i2cdac_pkg;

  // Transfer shape: address byte, control byte, then one payload byte.
  localparam int BYTES_PER_WRITE = 3;
  localparam int BITS_PER_BYTE   = 8;

  // Each byte owns its data bits plus one acknowledge slot.
  localparam int SLOTS_PER_BYTE = BITS_PER_BYTE + 1;
  localparam int LAST_BIT_SLOT  = BYTES_PER_WRITE * SLOTS_PER_BYTE;
  localparam int STOP_LOW_SLOT  = LAST_BIT_SLOT + 1;
  localparam int STOP_END_SLOT  = LAST_BIT_SLOT + 2;

  localparam int SLOT_W = $clog2(STOP_END_SLOT + 1);
  localparam int POS_W  = $clog2(SLOTS_PER_BYTE);
  localparam int BYTE_W = $clog2(BYTES_PER_WRITE + 1);
  localparam int HOLD_W = 16;
  localparam int DATA_W = 8;

  // Register reset values.
  localparam logic [DATA_W-1:0] DEV_ADDR_RST = 8'h90;
  localparam logic [DATA_W-1:0] CTRL_RST     = 8'h40;
  localparam logic [HOLD_W-1:0] HOLD_RST     = 16'd25;

  // Configuration register indexes.
  localparam int CFG_ADDR_W = 2;
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_DEVICE_ADDRESS = 2'd0,
    REG_CONTROL_BYTE   = 2'd1,
    REG_HOLD_TICKS     = 2'd2
  } cfg_reg_t;

  // Input word kinds carried on tuser.
  typedef enum logic {
    KIND_TICK  = 1'b0,
    KIND_WRITE = 1'b1
  } in_kind_t;

  // Result word, highest bit first.
  typedef struct packed {
    logic rejected;
    logic done_res;
    logic busy_res;
    logic data_pin;
    logic clock_pin;
  } result_t;

endpackage

// File: hw/rtl/i2c_dac_write_bitbang.sv
// Write-only two-wire bus master that sends one three-byte write (device address,
// control byte, latched data byte), MSB first, each byte followed by an acknowledge
// clock with data held low, framed by start and stop conditions. Every input word is
// either a time tick or a write request; each accepted word yields exactly one result
// word with the pin levels after it, busy, done on the tick that ends the stop step,
// and rejected when a request arrives while busy. Every pin step lasts hold_ticks
// ticks (0 acts as 1). The acknowledge is never sampled. One word is taken per clock
// cycle: the whole step is evaluated between the state registers and a single output
// register, and a new word is accepted whenever that register is empty or being read.
// Configuration must be written only while no transfer is in progress.
module i2c_dac_write_bitbang_core
  import i2cdac_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // Input channel
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] value
  input  logic                  in_tuser,   // [0] kind
  // Result channel
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [7:0]            out_tdata,  // [0] clock_pin, [1] data_pin, [2] busy_res,
                                            // [3] done_res, [4] rejected, [7:5] zero
  // Configuration port
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [HOLD_W-1:0]     cfg_wdata
);

  // Configuration registers
  logic [DATA_W-1:0] dev_addr_r;
  logic [DATA_W-1:0] ctrl_r;
  logic [HOLD_W-1:0] hold_ticks_r;

  // Sequencer state
  logic [SLOT_W-1:0] step_r, step_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [BYTE_W-1:0] byte_r, byte_nxt;
  logic [HOLD_W-1:0] hold_r, hold_nxt;
  logic [DATA_W-1:0] payload_r, payload_nxt;
  logic [DATA_W-1:0] shift_r, shift_nxt;
  logic              clk_lvl_r, clk_lvl_nxt;
  logic              dat_lvl_r, dat_lvl_nxt;
  logic              active_r, active_nxt;

  // Output register
  logic    out_valid_r;
  result_t out_res_r, res_nxt;

  logic              accept;
  logic              drv_go;
  logic              drv_first;
  logic [SLOT_W-1:0] drv_slot;
  logic [HOLD_W-1:0] hold_len;

  assign in_tready  = !out_valid_r || out_tready;
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_res_r};
  assign hold_len   = (hold_ticks_r == '0) ? HOLD_W'(1) : hold_ticks_r;

  // Next state for one word: a tick advances the pin sequence, a request starts it.
  always_comb begin
    step_nxt    = step_r;
    pos_nxt     = pos_r;
    byte_nxt    = byte_r;
    hold_nxt    = hold_r;
    payload_nxt = payload_r;
    shift_nxt   = shift_r;
    clk_lvl_nxt = clk_lvl_r;
    dat_lvl_nxt = dat_lvl_r;
    active_nxt  = active_r;
    drv_go      = 1'b0;
    drv_first   = 1'b0;
    drv_slot    = '0;
    res_nxt     = '0;

    if (accept) begin
      if (in_kind_t'(in_tuser) == KIND_WRITE) begin
        if (active_r) begin
          res_nxt.rejected = 1'b1;
        end else begin
          payload_nxt = in_tdata;
          active_nxt  = 1'b1;
          drv_go      = 1'b1;
          drv_first   = 1'b1;
          drv_slot    = '0;
        end
      end else if (active_r) begin
        if (hold_r > HOLD_W'(1)) begin
          hold_nxt = hold_r - HOLD_W'(1);
        end else if (step_r >= SLOT_W'(STOP_END_SLOT)) begin
          // Stop condition finished: back to an idle bus.
          active_nxt       = 1'b0;
          step_nxt         = '0;
          hold_nxt         = '0;
          clk_lvl_nxt      = 1'b1;
          dat_lvl_nxt      = 1'b1;
          res_nxt.done_res = 1'b1;
        end else if (step_r == '0) begin
          drv_go = 1'b1;
          if (clk_lvl_r) begin
            drv_slot  = '0;
            drv_first = 1'b0;
          end else begin
            drv_slot  = SLOT_W'(1);
            drv_first = 1'b1;
            pos_nxt   = '0;
            byte_nxt  = '0;
          end
        end else if (!clk_lvl_r) begin
          // Raise the clock on the current slot.
          drv_go    = 1'b1;
          drv_slot  = step_r;
          drv_first = 1'b0;
        end else begin
          // Clock high phase done: shift after a data bit, move to the next slot.
          if (step_r <= SLOT_W'(LAST_BIT_SLOT) && pos_r < POS_W'(BITS_PER_BYTE)) begin
            shift_nxt = {shift_r[DATA_W-2:0], 1'b0};
          end
          drv_go    = 1'b1;
          drv_slot  = step_r + SLOT_W'(1);
          drv_first = 1'b1;
          if (pos_r == POS_W'(SLOTS_PER_BYTE - 1)) begin
            pos_nxt  = '0;
            byte_nxt = byte_r + BYTE_W'(1);
          end else begin
            pos_nxt = pos_r + POS_W'(1);
          end
        end
      end

      // Drive the pins of the target slot and restart its hold count.
      if (drv_go) begin
        if (drv_slot == '0) begin
          clk_lvl_nxt = drv_first;
          dat_lvl_nxt = 1'b0;
        end else if (drv_slot <= SLOT_W'(LAST_BIT_SLOT)) begin
          if (drv_first && pos_nxt == '0) begin
            if (byte_nxt == '0) begin
              shift_nxt = dev_addr_r;
            end else if (byte_nxt == BYTE_W'(1)) begin
              shift_nxt = ctrl_r;
            end else begin
              shift_nxt = payload_nxt;
            end
          end
          dat_lvl_nxt = (pos_nxt < POS_W'(BITS_PER_BYTE)) ? shift_nxt[DATA_W-1] : 1'b0;
          clk_lvl_nxt = !drv_first;
        end else if (drv_slot == SLOT_W'(STOP_LOW_SLOT)) begin
          clk_lvl_nxt = !drv_first;
          dat_lvl_nxt = 1'b0;
        end else begin
          clk_lvl_nxt = 1'b1;
          dat_lvl_nxt = 1'b1;
        end
        step_nxt = drv_slot;
        hold_nxt = hold_len;
      end

      res_nxt.clock_pin = clk_lvl_nxt;
      res_nxt.data_pin  = dat_lvl_nxt;
      res_nxt.busy_res  = active_nxt;
    end
  end

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r   <= DEV_ADDR_RST;
      ctrl_r       <= CTRL_RST;
      hold_ticks_r <= HOLD_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_DEVICE_ADDRESS: dev_addr_r   <= cfg_wdata[DATA_W-1:0];
        REG_CONTROL_BYTE:   ctrl_r       <= cfg_wdata[DATA_W-1:0];
        REG_HOLD_TICKS:     hold_ticks_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Sequencer state and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= '0;
      pos_r       <= '0;
      byte_r      <= '0;
      hold_r      <= '0;
      payload_r   <= '0;
      shift_r     <= '0;
      clk_lvl_r   <= 1'b1;
      dat_lvl_r   <= 1'b1;
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
      out_res_r   <= '0;
    end else begin
      step_r    <= step_nxt;
      pos_r     <= pos_nxt;
      byte_r    <= byte_nxt;
      hold_r    <= hold_nxt;
      payload_r <= payload_nxt;
      shift_r   <= shift_nxt;
      clk_lvl_r <= clk_lvl_nxt;
      dat_lvl_r <= dat_lvl_nxt;
      active_r  <= active_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
        out_res_r   <= res_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import i2cdac_pkg::*;

  localparam int STALL_LIMIT = 4000;
  // Pin steps in one full transfer: start, data and ack bits, stop.
  localparam int STEPS_PER_WRITE = 2 * STOP_END_SLOT + 1;

  typedef struct packed {
    in_kind_t    kind;
    logic [7:0]  value;
  } bus_word_t;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata = '0;   // [7:0] value
  logic                  in_tuser = 1'b0; // [0] kind
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [7:0]            out_tdata;       // [0] clock_pin, [1] data_pin, [2] busy_res,
                                          // [3] done_res, [4] rejected, [7:5] zero
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [HOLD_W-1:0]     cfg_wdata = '0;

  // Words waiting to be sent and pin levels waiting to be seen.
  bus_word_t word_q[$];
  result_t   expected_pins_q[$];

  int  idle_mode = 0;
  int  words_queued = 0;
  int  mismatches = 0;
  int  quiet_cycles = 0;
  bit  word_taken = 1'b0;

  // Predicted register contents and sequencer state.
  logic [7:0]  reg_addr;
  logic [7:0]  reg_ctrl;
  logic [15:0] reg_hold;
  logic [6:0]  bus_step;
  logic [15:0] bus_hold;
  logic [7:0]  bus_payload;
  logic [7:0]  bus_shift;
  logic        bus_scl;
  logic        bus_sda;
  logic        bus_active;

  i2c_dac_write_bitbang_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // A hold of zero behaves as a hold of one.
  function automatic int effective_hold();
    return (reg_hold == 16'd0) ? 1 : int'(reg_hold);
  endfunction

  // Set the pins for the first or second half of a slot and restart the hold.
  function automatic void enter_step(int slot, bit first);
    int bit_pos;
    int byte_num;
    if (slot == 0) begin
      bus_scl = first;
      bus_sda = 1'b0;
    end else if (slot <= LAST_BIT_SLOT) begin
      bit_pos  = (slot - 1) % SLOTS_PER_BYTE;
      byte_num = (slot - 1) / SLOTS_PER_BYTE;
      // The byte to shift out is picked up as it begins.
      if (first && bit_pos == 0) begin
        if (byte_num == 0) bus_shift = reg_addr;
        else if (byte_num == 1) bus_shift = reg_ctrl;
        else bus_shift = bus_payload;
      end
      bus_sda = (bit_pos < BITS_PER_BYTE) ? bus_shift[7] : 1'b0;
      bus_scl = !first;
    end else if (slot == STOP_LOW_SLOT) begin
      bus_scl = !first;
      bus_sda = 1'b0;
    end else begin
      bus_scl = 1'b1;
      bus_sda = 1'b1;
    end
    bus_step = 7'(slot);
    bus_hold = 16'(effective_hold());
  endfunction

  // Move on to the next pin step; true when the stop step has ended.
  function automatic bit next_step();
    int slot;
    slot = int'(bus_step);
    if (slot >= STOP_END_SLOT) begin
      bus_active = 1'b0;
      bus_step   = '0;
      bus_hold   = '0;
      bus_scl    = 1'b1;
      bus_sda    = 1'b1;
      return 1'b1;
    end
    if (slot == 0) begin
      if (bus_scl) enter_step(0, 1'b0);
      else enter_step(1, 1'b1);
      return 1'b0;
    end
    if (!bus_scl) begin
      enter_step(slot, 1'b0);
    end else begin
      if (slot <= LAST_BIT_SLOT && ((slot - 1) % SLOTS_PER_BYTE) < BITS_PER_BYTE)
        bus_shift = bus_shift << 1;
      enter_step(slot + 1, 1'b1);
    end
    return 1'b0;
  endfunction

  // Pin levels and flags expected after one accepted word.
  function automatic result_t predict_pins(in_kind_t kind, logic [7:0] value);
    result_t r;
    bit      finished;
    bit      refused;
    finished = 1'b0;
    refused  = 1'b0;
    if (kind == KIND_WRITE) begin
      if (bus_active) begin
        refused = 1'b1;
      end else begin
        bus_payload = value;
        bus_active  = 1'b1;
        enter_step(0, 1'b1);
      end
    end else if (bus_active) begin
      if (bus_hold > 16'd1) bus_hold = bus_hold - 16'd1;
      else finished = next_step();
    end
    r.clock_pin = bus_scl;
    r.data_pin  = bus_sda;
    r.busy_res  = bus_active;
    r.done_res  = finished;
    r.rejected  = refused;
    return r;
  endfunction

  // Check results, predict accepted words and watch for a stalled run.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_pins_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result word %b", $time, out_tdata);
        end else if (out_tdata != {3'b000, expected_pins_q[0]}) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result mismatch (rej,done,busy,sda,scl): expected %b, got %b",
                     $time, {3'b000, expected_pins_q[0]}, out_tdata);
          void'(expected_pins_q.pop_front());
        end else begin
          void'(expected_pins_q.pop_front());
        end
      end
      if (in_tvalid && in_tready) begin
        expected_pins_q.push_back(predict_pins(in_kind_t'(in_tuser), in_tdata));
        void'(word_q.pop_front());
        word_taken = 1'b1;
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("testbench NOT OK");
          $finish;
        end
      end
    end
  end

  // Sender: present the oldest pending word, idling at random.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || word_taken) begin
      word_taken = 1'b0;
      if (word_q.size() > 0 &&
          $urandom_range(0, 99) >= ((idle_mode == 1) ? 83 : (idle_mode == 3) ? 9 : 0)) begin
        in_tvalid <= 1'b1;
        in_tuser  <= word_q[0].kind;
        in_tdata  <= word_q[0].value;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: stall at random according to the current phase.
  always @(negedge clk) begin
    out_tready <= $urandom_range(0, 99) >= ((idle_mode == 2) ? 83 : (idle_mode == 3) ? 9 : 0);
  end

  task automatic push_word(in_kind_t kind, logic [7:0] value);
    bus_word_t w;
    w.kind  = kind;
    w.value = value;
    word_q.push_back(w);
    words_queued++;
  endtask

  task automatic push_ticks(int count);
    repeat (count) push_word(KIND_TICK, 8'($urandom));
  endtask

  task automatic wait_drained();
    while (word_q.size() > 0 || expected_pins_q.size() > 0) @(posedge clk);
  endtask

  // Tick until no transfer is in progress and every result is in.
  task automatic settle_idle();
    wait_drained();
    while (bus_active) begin
      push_ticks(64);
      wait_drained();
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t which, logic [HOLD_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= which;
    cfg_wdata <= value;
    case (which)
      REG_DEVICE_ADDRESS: reg_addr = value[7:0];
      REG_CONTROL_BYTE:   reg_ctrl = value[7:0];
      REG_HOLD_TICKS:     reg_hold = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic configure(logic [7:0] addr, logic [7:0] ctrl, logic [15:0] hold, int mode);
    settle_idle();
    write_reg(REG_DEVICE_ADDRESS, {8'h00, addr});
    write_reg(REG_CONTROL_BYTE, {8'h00, ctrl});
    write_reg(REG_HOLD_TICKS, hold);
    idle_mode = mode;
  endtask

  // One write request followed by the ticks it needs, with the odd request
  // thrown in while busy; a cut-short run leaves the bus busy for the next one.
  task automatic send_transfer(logic [7:0] data, bit cut_short);
    int n;
    push_word(KIND_WRITE, data);
    n = STEPS_PER_WRITE * effective_hold();
    if (cut_short) n = $urandom_range(1, n);
    repeat (n) begin
      push_word(KIND_TICK, 8'($urandom));
      if ($urandom_range(0, 99) < 3) push_word(KIND_WRITE, 8'($urandom));
    end
    push_ticks($urandom_range(0, 2));
  endtask

  initial begin
    int phase;
    int random_start;
    reg_addr    = DEV_ADDR_RST;
    reg_ctrl    = CTRL_RST;
    reg_hold    = HOLD_RST;
    bus_step    = '0;
    bus_hold    = '0;
    bus_payload = '0;
    bus_shift   = '0;
    bus_scl     = 1'b1;
    bus_sda     = 1'b1;
    bus_active  = 1'b0;

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // Register reset values: idle tick, then a transfer whose start condition
    // runs at the reset hold; the hold is then shortened so all bytes go out.
    push_word(KIND_TICK, 8'hFF);
    push_word(KIND_WRITE, 8'hA5);
    push_ticks(60);
    wait_drained();
    write_reg(REG_HOLD_TICKS, 16'd1);
    push_ticks(90);

    // Zero hold, extreme bytes, request while busy, back-to-back transfers.
    configure(8'hFF, 8'h00, 16'h0000, 1);
    push_word(KIND_WRITE, 8'hFF);
    push_word(KIND_WRITE, 8'h00);
    push_ticks(STEPS_PER_WRITE);
    send_transfer(8'h00, 1'b0);
    push_word(KIND_TICK, 8'h00);

    configure(8'h00, 8'hFF, 16'h0001, 2);
    send_transfer(8'($urandom), 1'b1);
    send_transfer(8'($urandom), 1'b0);

    // Random settings and payloads, cycling through the idling phases.
    phase = 3;
    random_start = words_queued;
    while (words_queued - random_start < 100) begin
      configure(8'($urandom), 8'($urandom),
                ($urandom_range(0, 9) < 7) ? 16'd1 : 16'd2, phase % 4);
      send_transfer(8'($urandom), $urandom_range(0, 9) == 0);
      phase++;
    end

    // Longest hold: only the opening step fits in the run.
    configure(8'($urandom), 8'($urandom), 16'hFFFF, 0);
    push_word(KIND_WRITE, 8'($urandom));
    push_ticks(40);
    push_word(KIND_WRITE, 8'($urandom));
    push_ticks(10);

    wait_drained();
    repeat (16) @(posedge clk);
    if (mismatches == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
